### rtl/gtrg_pkg.sv
// Shared types, constants and font helper functions for the glyph rectangle generator.
package gtrg_pkg;

  localparam int CELL_ROWS   = 7;
  localparam int CELL_COLS   = 5;
  localparam int CELLS       = CELL_ROWS * CELL_COLS;
  localparam int CODES       = 256;
  localparam int STORE_DEPTH = CODES * CELLS;
  localparam int ADDR_W      = 14;
  localparam int CELL_W      = 25;
  localparam int RGB_W       = 24;
  localparam int COORD_W     = 18;
  localparam int SURF_W      = 13;
  localparam int POS_W       = 12;
  localparam int DIM_W       = 4;
  localparam int CLIP_MAX    = 4096;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int OCC_BIT     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 2'd1;

  localparam logic REQ_WRITE = 1'b1;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] BINARY_CODES = 8'd32;

  localparam logic [4:0] ROW_FULL  = 5'h1F;
  localparam logic [4:0] ROW_SIDES = 5'h11;
  localparam logic [4:0] ROW_BOX   = 5'h15;
  localparam logic [4:0] ROW_DOT   = 5'h04;

  localparam logic [2:0] LAST_ROW = 3'(CELL_ROWS - 1);
  localparam logic [2:0] LAST_COL = 3'(CELL_COLS - 1);

  typedef enum logic [1:0] {
    OP_NOP,
    OP_DRAW,
    OP_WRITE
  } op_t;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_IDLE,
    BK_DRAW
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic [7:0]                code;
    logic signed [COORD_W-1:0] bx;
    logic signed [15:0]        by;
    logic [RGB_W-1:0]          tint;
    logic [2:0]                row;
    logic [2:0]                col;
    logic                      on;
    logic [RGB_W-1:0]          rgb;
  } qentry_t;

  typedef struct packed {
    logic                      v;
    logic                      fin;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RGB_W-1:0]          tint;
  } cell_tag_t;

  typedef struct packed {
    logic [SURF_W-1:0] width;
    logic [SURF_W-1:0] height;
  } clip_cfg_t;

  function automatic logic [ADDR_W-1:0] glyph_addr(input logic [7:0] code,
                                                   input logic [2:0] row,
                                                   input logic [2:0] col);
    glyph_addr = ADDR_W'(code) * ADDR_W'(CELLS) + ADDR_W'(row) * ADDR_W'(CELL_COLS)
               + ADDR_W'(col);
  endfunction

  function automatic logic [4:0] box_row(input logic [2:0] row);
    logic [4:0] bits;
    unique case (row)
      3'd0:             bits = ROW_FULL;
      3'd1, 3'd5:       bits = ROW_SIDES;
      3'd2, 3'd3, 3'd4: bits = ROW_BOX;
      default:          bits = ROW_FULL;
    endcase
    return bits;
  endfunction

  function automatic logic [CELL_W-1:0] fallback_cell(input logic [7:0] code,
                                                      input logic [2:0] row,
                                                      input logic [2:0] col);
    logic [4:0] bits;
    logic [2:0] sel;
    logic       on;
    bits = box_row(row);
    sel  = 3'd5 - row;
    if (code == SPACE_CODE) begin
      bits = '0;
    end else if (code < BINARY_CODES) begin
      if (row == 3'd0 || row == LAST_ROW) begin
        bits = ROW_FULL;
      end else begin
        bits = ROW_SIDES | (code[sel] ? ROW_DOT : 5'd0);
      end
    end
    on = bits[3'd4 - col];
    return on ? {1'b1, {RGB_W{1'b1}}} : '0;
  endfunction

endpackage

### rtl/glyph_text_rect_generator_unit.sv
// Top level of the 5x7 glyph rectangle generator.
// Command channel: a beat is taken at a clock edge with start high and busy low.
// A draw beat with an index below MAX_STRING scans the 35 cells of one glyph and
// emits one fill rectangle per occupied cell that survives clipping, in row-major
// order; a write beat with an in-range cell replaces it and emits nothing.
// Results leave on the out_ ports for one cycle each, marked by out_valid;
// out_last_rect flags the final rectangle of a character. The receiver cannot
// stall, so every result is taken in the cycle it is shown.
// Path: a draw beat passes the queue, the cell sequencer with its registered memory
// read, the s2_ stage, the hold register and the output register; the last
// rectangle also waits for a flush when the bottom-right cell is visible.
// Occupancy: a draw holds the cell sequencer for its dequeue and 35 memory reads
// on the single read port; a write holds it only for its dequeue.
// A two-entry queue holds beats while the sequencer works; busy rises when full.
// Reset: a sweep loads the fallback font into the 8960-entry glyph memory, one
// entry per cycle; busy stays high meanwhile. Configuration writes on the cfg_
// channel are always ready and take effect at once.
module glyph_text_rect_generator_unit import gtrg_pkg::*; #(
  parameter int GLYPH_SCALE   = 2,
  parameter int GLYPH_ADVANCE = 12,
  parameter int MAX_STRING    = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic [7:0]           in_char_code,
  input  logic [7:0]           in_char_index,
  input  logic signed [15:0]   in_pos_x,
  input  logic signed [15:0]   in_pos_y,
  input  logic [RGB_W-1:0]     in_tint_color,
  input  logic [2:0]           in_glyph_row,
  input  logic [2:0]           in_glyph_col,
  input  logic                 in_pixel_on,
  input  logic [RGB_W-1:0]     in_pixel_rgb,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_rect_x,
  output logic [POS_W-1:0]     out_rect_y,
  output logic [DIM_W-1:0]     out_rect_w,
  output logic [DIM_W-1:0]     out_rect_h,
  output logic [RGB_W-1:0]     out_fill_color,
  output logic                 out_last_rect,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SURF_W-1:0]    cfg_data
);

  clip_cfg_t clip_r;
  logic      push, pop, q_full, q_empty, init_done;
  qentry_t   push_data, head;
  cell_tag_t tag;
  logic [CELL_W-1:0] cell_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.width  <= SURF_W'(640);
      clip_r.height <= SURF_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SURFACE_WIDTH:  clip_r.width  <= cfg_data;
        CFG_SURFACE_HEIGHT: clip_r.height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gtrg_front #(
    .GLYPH_ADVANCE(GLYPH_ADVANCE),
    .MAX_STRING   (MAX_STRING)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_char_code  (in_char_code),
    .in_char_index (in_char_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_tint_color (in_tint_color),
    .in_glyph_row  (in_glyph_row),
    .in_glyph_col  (in_glyph_col),
    .in_pixel_on   (in_pixel_on),
    .in_pixel_rgb  (in_pixel_rgb),
    .init_done     (init_done),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  gtrg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gtrg_back #(
    .GLYPH_SCALE(GLYPH_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .init_done (init_done),
    .tag       (tag),
    .cell_data (cell_data)
  );

  gtrg_shade #(
    .GLYPH_SCALE(GLYPH_SCALE)
  ) u_shade (
    .clk            (clk),
    .rst_n          (rst_n),
    .clip           (clip_r),
    .tag            (tag),
    .cell_data      (cell_data),
    .out_valid      (out_valid),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_fill_color (out_fill_color),
    .out_last_rect  (out_last_rect)
  );

endmodule

### rtl/gtrg_front.sv
// Front end: accepts command beats, classifies them and forms queue entries.
module gtrg_front import gtrg_pkg::*; #(
  parameter int GLYPH_ADVANCE = 12,
  parameter int MAX_STRING    = 256
) (
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_char_index,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [RGB_W-1:0]   in_tint_color,
  input  logic [2:0]         in_glyph_row,
  input  logic [2:0]         in_glyph_col,
  input  logic               in_pixel_on,
  input  logic [RGB_W-1:0]   in_pixel_rgb,
  input  logic               init_done,
  input  logic               q_full,
  output logic               push,
  output qentry_t            push_data
);

  logic signed [COORD_W-1:0] advance_off;

  assign busy = ~init_done | q_full;
  assign push = start & ~busy;

  always_comb begin
    advance_off    = COORD_W'(32'(in_char_index) * GLYPH_ADVANCE);
    push_data      = '0;
    push_data.code = in_char_code;
    push_data.bx   = COORD_W'(in_pos_x) + advance_off;
    push_data.by   = in_pos_y;
    push_data.tint = in_tint_color;
    push_data.row  = in_glyph_row;
    push_data.col  = in_glyph_col;
    push_data.on   = in_pixel_on;
    push_data.rgb  = in_pixel_rgb;
    if (in_req_type == REQ_WRITE) begin
      push_data.op = (in_glyph_row <= LAST_ROW && in_glyph_col <= LAST_COL) ? OP_WRITE : OP_NOP;
    end else begin
      push_data.op = (32'(in_char_index) < MAX_STRING) ? OP_DRAW : OP_NOP;
    end
  end

endmodule

### rtl/gtrg_queue.sv
// Short queue that decouples the front end from the drawing back end.
module gtrg_queue import gtrg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  input  logic    pop,
  output qentry_t head,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");

endmodule

### rtl/gtrg_back.sv
// Back end sequencer: font memory, reset sweep, glyph writes and cell scan.
module gtrg_back import gtrg_pkg::*; #(
  parameter int GLYPH_SCALE = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  qentry_t           head,
  output logic              pop,
  output logic              init_done,
  output cell_tag_t         tag,
  output logic [CELL_W-1:0] cell_data
);

  back_state_t state_r, state_nxt;

  logic [CELL_W-1:0] glyph_mem [STORE_DEPTH];
  logic [CELL_W-1:0] rdata_r;
  cell_tag_t         tag_r;

  logic [7:0] init_code_r;
  logic [2:0] init_row_r, init_col_r;
  logic [2:0] cur_row_r, cur_col_r;

  logic [7:0]                ctx_code_r;
  logic signed [COORD_W-1:0] ctx_bx_r;
  logic signed [15:0]        ctx_by_r;
  logic [RGB_W-1:0]          ctx_tint_r;

  logic              init_cell_last, init_last, cur_last;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  assign init_cell_last = (init_row_r == LAST_ROW) && (init_col_r == LAST_COL);
  assign init_last      = init_cell_last && (init_code_r == 8'(CODES - 1));
  assign cur_last       = (cur_row_r == LAST_ROW) && (cur_col_r == LAST_COL);
  assign init_done      = (state_r != BK_INIT);
  assign tag            = tag_r;
  assign cell_data      = rdata_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_INIT: begin
        if (init_last) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty && head.op == OP_DRAW) state_nxt = BK_DRAW;
      end
      BK_DRAW: begin
        if (cur_last) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_INIT;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = glyph_addr(head.code, head.row, head.col);
    mem_wdata = {head.on, head.rgb};
    mem_raddr = glyph_addr(ctx_code_r, cur_row_r, cur_col_r);
    unique case (state_r)
      BK_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = glyph_addr(init_code_r, init_row_r, init_col_r);
        mem_wdata = fallback_cell(init_code_r, init_row_r, init_col_r);
      end
      BK_IDLE: begin
        pop    = !q_empty;
        mem_we = !q_empty && (head.op == OP_WRITE);
      end
      BK_DRAW: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      init_code_r <= '0;
      init_row_r  <= '0;
      init_col_r  <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      tag_r.v     <= 1'b0;
      tag_r.fin   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_INIT) begin
        if (init_col_r == LAST_COL) begin
          init_col_r <= '0;
          if (init_row_r == LAST_ROW) begin
            init_row_r  <= '0;
            init_code_r <= init_code_r + 1'b1;
          end else begin
            init_row_r <= init_row_r + 1'b1;
          end
        end else begin
          init_col_r <= init_col_r + 1'b1;
        end
      end
      if (pop && head.op == OP_DRAW) begin
        cur_row_r <= '0;
        cur_col_r <= '0;
      end else if (state_r == BK_DRAW) begin
        if (cur_col_r == LAST_COL) begin
          cur_col_r <= '0;
          cur_row_r <= (cur_row_r == LAST_ROW) ? '0 : cur_row_r + 1'b1;
        end else begin
          cur_col_r <= cur_col_r + 1'b1;
        end
      end
      tag_r.v    <= (state_r == BK_DRAW);
      tag_r.fin  <= (state_r == BK_DRAW) && cur_last;
      tag_r.x    <= ctx_bx_r + COORD_W'(32'(cur_col_r) * GLYPH_SCALE);
      tag_r.y    <= COORD_W'(ctx_by_r) + COORD_W'(32'(cur_row_r) * GLYPH_SCALE);
      tag_r.tint <= ctx_tint_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.op == OP_DRAW) begin
      ctx_code_r <= head.code;
      ctx_bx_r   <= head.bx;
      ctx_by_r   <= head.by;
      ctx_tint_r <= head.tint;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      glyph_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= glyph_mem[mem_raddr];
  end

endmodule

### rtl/gtrg_shade.sv
// Clipping, tinting and last-rectangle marking of scanned glyph cells.
module gtrg_shade import gtrg_pkg::*; #(
  parameter int GLYPH_SCALE = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  clip_cfg_t         clip,
  input  cell_tag_t         tag,
  input  logic [CELL_W-1:0] cell_data,
  output logic              out_valid,
  output logic [POS_W-1:0]  out_rect_x,
  output logic [POS_W-1:0]  out_rect_y,
  output logic [DIM_W-1:0]  out_rect_w,
  output logic [DIM_W-1:0]  out_rect_h,
  output logic [RGB_W-1:0]  out_fill_color,
  output logic              out_last_rect
);

  logic [SURF_W-1:0]         wlim, hlim;
  logic signed [COORD_W-1:0] x1, y1, wl, hl, left, right, top, bottom;
  logic                      vis;
  logic [2:0][15:0]          prod, qsum;
  logic [RGB_W-1:0]          color;

  logic                 s2_v_r, s2_fin_r, s2_vis_r;
  logic [POS_W-1:0]     s2_x_r, s2_y_r;
  logic [DIM_W-1:0]     s2_w_r, s2_h_r;
  logic [2:0][15:0]     s2_prod_r;

  logic                 hold_v_r, hold_v_nxt;
  logic                 flush_r, flush_nxt;
  logic                 load_hold;
  logic [POS_W-1:0]     hold_x_r, hold_y_r;
  logic [DIM_W-1:0]     hold_w_r, hold_h_r;
  logic [RGB_W-1:0]     hold_color_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [POS_W-1:0]     out_x_r, out_y_r;
  logic [DIM_W-1:0]     out_w_r, out_h_r;
  logic [RGB_W-1:0]     out_color_r;

  logic cand_vis, cand_fin;

  always_comb begin
    wlim   = (clip.width > SURF_W'(CLIP_MAX)) ? SURF_W'(CLIP_MAX) : clip.width;
    hlim   = (clip.height > SURF_W'(CLIP_MAX)) ? SURF_W'(CLIP_MAX) : clip.height;
    wl     = COORD_W'(wlim);
    hl     = COORD_W'(hlim);
    x1     = tag.x + COORD_W'(GLYPH_SCALE);
    y1     = tag.y + COORD_W'(GLYPH_SCALE);
    left   = (tag.x > 0) ? tag.x : '0;
    top    = (tag.y > 0) ? tag.y : '0;
    right  = (x1 < wl) ? x1 : wl;
    bottom = (y1 < hl) ? y1 : hl;
    vis    = cell_data[OCC_BIT] && (right > left) && (bottom > top);
    for (int i = 0; i < 3; i++) begin
      prod[i] = 16'(cell_data[8*i +: 8]) * 16'(tag.tint[8*i +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r   <= 1'b0;
      s2_fin_r <= 1'b0;
    end else begin
      s2_v_r   <= tag.v;
      s2_fin_r <= tag.fin;
    end
  end

  always_ff @(posedge clk) begin
    s2_vis_r  <= vis;
    s2_x_r    <= POS_W'(left);
    s2_y_r    <= POS_W'(top);
    s2_w_r    <= DIM_W'(right - left);
    s2_h_r    <= DIM_W'(bottom - top);
    s2_prod_r <= prod;
  end

  // Floor division by 255 of a product of two bytes: (p + (p >> 8) + 1) >> 8.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qsum[i]          = s2_prod_r[i] + (s2_prod_r[i] >> 8) + 16'd1;
      color[8*i +: 8]  = qsum[i][15:8];
    end
  end

  assign cand_vis = s2_v_r && s2_vis_r;
  assign cand_fin = s2_v_r && s2_fin_r;

  // A visible rectangle waits in the hold register until the next one or the
  // end of its character shows whether it is the last.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_last_nxt  = 1'b0;
    hold_v_nxt    = hold_v_r;
    flush_nxt     = 1'b0;
    load_hold     = 1'b0;
    priority if (flush_r) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      hold_v_nxt    = cand_vis;
      load_hold     = cand_vis;
    end else if (cand_vis) begin
      out_valid_nxt = hold_v_r;
      hold_v_nxt    = 1'b1;
      load_hold     = 1'b1;
      flush_nxt     = cand_fin;
    end else if (cand_fin) begin
      out_valid_nxt = hold_v_r;
      out_last_nxt  = hold_v_r;
      hold_v_nxt    = 1'b0;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      hold_v_r    <= hold_v_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_x_r     <= s2_x_r;
      hold_y_r     <= s2_y_r;
      hold_w_r     <= s2_w_r;
      hold_h_r     <= s2_h_r;
      hold_color_r <= color;
    end
    out_x_r     <= hold_x_r;
    out_y_r     <= hold_y_r;
    out_w_r     <= hold_w_r;
    out_h_r     <= hold_h_r;
    out_color_r <= hold_color_r;
  end

  assign out_valid      = out_valid_r;
  assign out_last_rect  = out_last_r;
  assign out_rect_x     = out_x_r;
  assign out_rect_y     = out_y_r;
  assign out_rect_w     = out_w_r;
  assign out_rect_h     = out_h_r;
  assign out_fill_color = out_color_r;

  a_rect_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_w_r != '0) && (out_w_r <= DIM_W'(GLYPH_SCALE))
                 && (out_h_r != '0) && (out_h_r <= DIM_W'(GLYPH_SCALE)))
    else $error("rectangle size out of range");

  a_flush_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> hold_v_r)
    else $error("flush without a held rectangle");

  a_flush_no_second_end: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !cand_fin)
    else $error("character end during flush");

  a_last_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_last_nxt && !cand_vis) |=> !hold_v_r)
    else $error("hold still valid after last rectangle");

endmodule
